/* rtl/eca_pkg.sv */
// Package for the elementary cellular automaton block.
// Holds the word types of both channels, the cell control struct and fixed widths.
// No dependencies.
package eca_pkg;

    localparam int RULE_W = 8;
    localparam int IDX_W  = 6;
    localparam int ROW_W  = 64;
    localparam int CNT_W  = 7;
    localparam int GRP_W  = 8;
    localparam int GRP_N  = ROW_W / GRP_W;
    localparam int GCNT_W = $clog2(GRP_W + 1);

    localparam logic [RULE_W-1:0] RULE_RESET = 8'd30;

    typedef enum logic {
        REQ_SEED   = 1'b0,
        REQ_EVOLVE = 1'b1
    } eca_req_t;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] cell_index;
    } eca_in_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_bits;
        logic [CNT_W-1:0] active_count;
        logic [CNT_W-1:0] cell_total;
    } eca_out_t;

    typedef struct packed {
        logic seed;
        logic evolve;
    } eca_ctl_t;

endpackage

/* rtl/elementary_cellular_automaton.sv */
// Elementary cellular automaton: a cyclic row of cells evolved by a Wolfram rule.
// An accepted word passes through the cell row, stage 2 and the output register.
// Throughput: one word per cycle while the output is not stalled; every cell updates in parallel.
// Reset (synchronous, active low) clears the row and all totals, empties the
// pipeline and loads rule 30. Depends on eca_pkg, eca_cell and eca_grp_count.
module elementary_cellular_automaton import eca_pkg::*; #(
    parameter int CELL_COUNT = 64,
    parameter int TOTAL_BITS = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [RULE_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  eca_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output eca_out_t          m_data
);

    // The middle cell is the one a seed word lights.
    localparam int MID_CELL = (CELL_COUNT - 1) / 2;
    localparam int SEL_W    = $clog2(CELL_COUNT);
    localparam logic [IDX_W:0] CELL_LIM = (IDX_W + 1)'(CELL_COUNT);

    // The whole pipeline moves as one: it advances whenever the output register
    // is empty or is being drained. Cells only change on an accepted word, so a
    // stall freezes the row along with everything downstream of it.
    logic advance;
    logic accept;

    logic [RULE_W-1:0] rule_reg;

    // Stage 1 is the cell row itself plus the word's bookkeeping.
    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_sel_reg;

    // Stage 2 holds a snapshot of the row, per-group counts and the chosen total.
    logic             p2_valid_reg;
    logic [ROW_W-1:0] p2_row_reg;
    logic [CNT_W-1:0] p2_total_reg;
    logic [GCNT_W-1:0] grp_cnt [GRP_N];

    logic     m_valid_reg;
    eca_out_t m_data_reg;

    eca_ctl_t               cell_ctl;
    logic [CELL_COUNT-1:0]  row_now;
    logic [TOTAL_BITS-1:0]  cell_tot [CELL_COUNT];
    logic [CNT_W-1:0]       cell_tot_w [CELL_COUNT];
    logic [ROW_W-1:0]       row_pad;
    logic [CNT_W-1:0]       total_sel;
    logic [CNT_W-1:0]       count_sum;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    assign cell_ctl.seed   = accept && (s_data.req_type == REQ_SEED);
    assign cell_ctl.evolve = accept && (s_data.req_type == REQ_EVOLVE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg <= RULE_RESET;
        end else if (cfg_wr_en) begin
            rule_reg <= cfg_wr_data;
        end
    end

    // The row of cells. Cell i sees cell i-1 on its left and cell i+1 on its
    // right; both ends wrap around.
    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
        eca_cell #(
            .TOTAL_BITS (TOTAL_BITS),
            .IS_MID     (i == MID_CELL)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (cell_ctl),
            .rule      (rule_reg),
            .left_bit  (row_now[(i + CELL_COUNT - 1) % CELL_COUNT]),
            .right_bit (row_now[(i + 1) % CELL_COUNT]),
            .state_bit (row_now[i]),
            .total     (cell_tot[i])
        );

        // The reported total is the low bits of the count, zero-extended when
        // the count is narrower than the result field.
        if (TOTAL_BITS >= CNT_W) begin : g_trunc
            assign cell_tot_w[i] = cell_tot[i][CNT_W-1:0];
        end else begin : g_ext
            assign cell_tot_w[i] = {{(CNT_W - TOTAL_BITS){1'b0}}, cell_tot[i]};
        end
    end

    // Bits beyond the row read as zero in the result.
    for (genvar j = 0; j < ROW_W; j++) begin : g_pad
        if (j < CELL_COUNT) begin : g_live
            assign row_pad[j] = row_now[j];
        end else begin : g_zero
            assign row_pad[j] = 1'b0;
        end
    end

    // A selected cell beyond the row reports zero.
    always_comb begin
        total_sel = '0;
        if ({1'b0, p1_sel_reg} < CELL_LIM) begin
            total_sel = cell_tot_w[p1_sel_reg[SEL_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= s_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_sel_reg   <= s_data.cell_index;
            p2_row_reg   <= row_pad;
            p2_total_reg <= total_sel;
        end
    end

    // Active cells are counted in two steps: per group into stage 2, then the
    // group counts are summed into the output register.
    for (genvar g = 0; g < GRP_N; g++) begin : g_grp
        eca_grp_count u_grp (
            .aclk    (aclk),
            .en      (advance),
            .bits_in (row_pad[g*GRP_W +: GRP_W]),
            .count   (grp_cnt[g])
        );
    end

    always_comb begin
        count_sum = '0;
        for (int g = 0; g < GRP_N; g++) begin
            count_sum = count_sum + CNT_W'(grp_cnt[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.row_bits     <= p2_row_reg;
            m_data_reg.active_count <= count_sum;
            m_data_reg.cell_total   <= p2_total_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A seed word leaves exactly the middle cell lit.
    a_seed_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.req_type == REQ_SEED)) |=>
            (row_now == (CELL_COUNT'(1) << MID_CELL)))
        else $error("seed did not leave only the middle cell active");

    // While input is held off, the row must not move.
    a_stall_row: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(row_now))
        else $error("row changed without an accepted word");

    // A reported count never exceeds the row length.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.active_count <= CNT_W'(CELL_COUNT)))
        else $error("active count beyond row length");

    // The reported count agrees with the reported row.
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.active_count == CNT_W'($countones(m_data.row_bits))))
        else $error("active count disagrees with row bits");

endmodule

/* rtl/eca_cell.sv */
// One cell of the automaton row: its state bit and saturating activity total.
// Depends on eca_pkg for the control struct and rule width.
module eca_cell import eca_pkg::*; #(
    parameter int TOTAL_BITS = 7,
    parameter bit IS_MID     = 1'b0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  eca_ctl_t              ctl,
    input  logic [RULE_W-1:0]     rule,
    input  logic                  left_bit,
    input  logic                  right_bit,
    output logic                  state_bit,
    output logic [TOTAL_BITS-1:0] total
);

    logic                  state_reg, state_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [2:0]            pattern;

    assign pattern = {left_bit, state_reg, right_bit};

    always_comb begin
        state_next = state_reg;
        total_next = total_reg;
        if (ctl.seed) begin
            state_next = IS_MID;
            total_next = TOTAL_BITS'(IS_MID);
        end else if (ctl.evolve) begin
            state_next = rule[pattern];
            if (rule[pattern] && (total_reg != {TOTAL_BITS{1'b1}})) begin
                total_next = total_reg + TOTAL_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= 1'b0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
    end

    assign state_bit = state_reg;
    assign total     = total_reg;

endmodule

/* rtl/eca_grp_count.sv */
// Registered population count of one group of row bits.
// Depends on eca_pkg for the group widths.
module eca_grp_count import eca_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [GRP_W-1:0]  bits_in,
    output logic [GCNT_W-1:0] count
);

    logic [GCNT_W-1:0] count_reg, count_next;

    always_comb begin
        count_next = '0;
        for (int i = 0; i < GRP_W; i++) begin
            count_next = count_next + GCNT_W'(bits_in[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the elementary cellular automaton block.
// Drives seed and evolve words through the valid/ready channels and checks every result word against a
// behavioral copy of the automaton or a hand-typed expectation. Depends on eca_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
    import eca_pkg::*;

    localparam int CELLS          = 64;
    localparam int TOTAL_BITS     = 7;
    localparam int TOTAL_MAX      = (1 << TOTAL_BITS) - 1;
    localparam int MID_CELL       = (CELLS - 1) / 2;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 8;
    // Quiet time after the last expected result, long enough to see any
    // stray word.
    localparam int SETTLE_CYCLES  = 8;
    // The longest correct stretch without any handshake is the deliberate
    // receiver hold-off below; the watchdog allows ten times that.
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_WORD   = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [ROW_W-1:0] MID_ONLY = 64'h0000_0000_8000_0000;
    localparam logic [ROW_W-1:0] ALL_ON   = {ROW_W{1'b1}};

    // One line of the directed table. A row may first load a new rule, and
    // its expected result is typed in only where it is obvious by hand.
    typedef struct {
        logic              load_rule;
        logic [RULE_W-1:0] rule;
        eca_req_t          req;
        logic [IDX_W-1:0]  idx;
        logic              typed;
        logic [ROW_W-1:0]  row;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  total;
    } plan_row_t;

    // One stretch of random words under a single rule; a negative rule
    // means a random one, and seed_one_in of zero means no seeds after the first word.
    typedef struct {
        int rule;
        int words;
        int seed_one_in;
    } phase_t;

    logic     aclk;
    logic     aresetn;
    logic     cfg_wr_en;
    logic     [RULE_W-1:0] cfg_wr_data;
    logic     s_valid;
    logic     s_ready;
    eca_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    eca_out_t m_data;

    // Our own copy of the automaton: the row, the per-cell totals and the rule.
    logic [ROW_W-1:0]  model_row;
    int unsigned       model_totals [CELLS];
    logic [RULE_W-1:0] model_rule;

    eca_out_t predicted_gens [$];
    plan_row_t directed [$];
    phase_t    phases [$];

    int mismatches;
    int accepted_words;
    int burst_left;
    int quiet_cycles;
    bit hold_done;

    elementary_cellular_automaton #(
        .CELL_COUNT (CELLS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
                                   input logic [ROW_W-1:0] want);
        $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Applies one word to our copy of the automaton and returns the result
    // word the block should give for it. A seed leaves only the middle cell
    // lit; an evolve looks up every cell's (left, self, right) pattern in
    // the rule, with the row wrapping around at both ends.
    task automatic compute_generation(input eca_in_t w, output eca_out_t gen);
        logic [ROW_W-1:0] next_row;
        logic [2:0]       pattern;
        int               left_pos;
        int               right_pos;
        int               lit;
        if (eca_req_t'(w.req_type) == REQ_SEED) begin
            model_row = '0;
            model_row[MID_CELL] = 1'b1;
            foreach (model_totals[i]) model_totals[i] = 0;
            model_totals[MID_CELL] = 1 & TOTAL_MAX;
        end else begin
            next_row = '0;
            for (int i = 0; i < CELLS; i++) begin
                left_pos  = (i + CELLS - 1) % CELLS;
                right_pos = (i + 1) % CELLS;
                pattern = {model_row[left_pos], model_row[i], model_row[right_pos]};
                next_row[i] = model_rule[pattern];
                // Totals only count up, and stick at their maximum.
                if (next_row[i] && model_totals[i] < TOTAL_MAX) begin
                    model_totals[i]++;
                end
            end
            model_row = next_row;
        end
        lit = $countones(model_row);
        gen.row_bits     = model_row;
        gen.active_count = lit[CNT_W-1:0];
        if (w.cell_index < CELLS) begin
            gen.cell_total = model_totals[w.cell_index][CNT_W-1:0];
        end else begin
            gen.cell_total = '0;
        end
    endtask

    // Offers one word and returns at the edge where it is taken. The sender
    // works in bursts: when a burst runs out it may drop valid for a random
    // gap before the next one starts. The predictor always advances, but a
    // hand-typed expectation replaces its result when one is given.
    task automatic offer_word(input eca_in_t w, input logic use_typed,
                              input eca_out_t typed_gen);
        eca_out_t gen;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        compute_generation(w, gen);
        predicted_gens.push_back(use_typed ? typed_gen : gen);
        accepted_words++;
    endtask

    // Stops the sender and waits until every predicted word has come back,
    // plus a margin for anything still inside the pipeline.
    task automatic drain_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (predicted_gens.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The block must be idle here; the rule takes effect for the next word.
    task automatic load_rule(input logic [RULE_W-1:0] rule);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rule;
        model_rule = rule;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic plan_row_t plan(input logic load, input logic [RULE_W-1:0] rule,
                                       input eca_req_t req, input logic [IDX_W-1:0] idx,
                                       input logic typed, input logic [ROW_W-1:0] row,
                                       input logic [CNT_W-1:0] count,
                                       input logic [CNT_W-1:0] total);
        plan_row_t p;
        p.load_rule = load;
        p.rule      = rule;
        p.req       = req;
        p.idx       = idx;
        p.typed     = typed;
        p.row       = row;
        p.count     = count;
        p.total     = total;
        return p;
    endfunction

    function automatic phase_t phase(input int rule, input int words, input int seed_one_in);
        phase_t ph;
        ph.rule        = rule;
        ph.words       = words;
        ph.seed_one_in = seed_one_in;
        return ph;
    endfunction

    // Receiver: ready follows a changing pattern of its own, from always
    // ready to mostly stalled. Once, well into the run, it holds off for a
    // long stretch while the sender keeps offering, so the pipeline fills
    // and the block has to push back on its input.
    initial begin : receiver
        int span;
        int mode;
        m_ready = 1'b0;
        forever begin
            if (!hold_done && accepted_words >= HOLD_AT_WORD) begin
                hold_done = 1'b1;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(1, 60);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 4) == 0);
                    end
                endcase
            end
        end
    end

    // Result checker and watchdog. Both sample at the rising edge, where
    // outputs still hold the values set up during the previous cycle.
    always @(posedge aclk) begin : result_check
        eca_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_gens.size() == 0) begin
                report_mismatch("result word with nothing expected", m_data.row_bits, '0);
            end else begin
                want = predicted_gens.pop_front();
                if (m_data.row_bits !== want.row_bits) begin
                    report_mismatch("row_bits", m_data.row_bits, want.row_bits);
                end
                if (m_data.active_count !== want.active_count) begin
                    report_mismatch("active_count", ROW_W'(m_data.active_count),
                                    ROW_W'(want.active_count));
                end
                if (m_data.cell_total !== want.cell_total) begin
                    report_mismatch("cell_total", ROW_W'(m_data.cell_total),
                                    ROW_W'(want.cell_total));
                end
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        eca_in_t   w;
        eca_out_t  typed_gen;
        plan_row_t p;
        phase_t    ph;
        int        rule;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        mismatches     = 0;
        accepted_words = 0;
        burst_left     = 0;
        quiet_cycles   = 0;
        hold_done      = 1'b0;

        // After reset the row is dark, every total is zero and rule 30 is loaded.
        model_row = '0;
        foreach (model_totals[i]) model_totals[i] = 0;
        model_rule = RULE_RESET;

        // Directed part. The first rows run under the reset rule and evolve
        // before any seed. Rule 0 kills every cell, rule 255 lights them
        // all, and rule 204 copies each cell onto itself, so those rows can
        // be worked out by hand. The selected cell visits both ends of the
        // row and the middle.
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 0,  1, '0,       0,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 63, 1, '0,       0,  0));
        directed.push_back(plan(0, 0,   REQ_SEED,   31, 1, MID_ONLY, 1,  1));
        directed.push_back(plan(0, 0,   REQ_SEED,   0,  1, MID_ONLY, 1,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 30, 0, '0,       0,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 32, 0, '0,       0,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 63, 0, '0,       0,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 31, 0, '0,       0,  0));
        directed.push_back(plan(1, 0,   REQ_SEED,   31, 1, MID_ONLY, 1,  1));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 31, 1, '0,       0,  1));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 62, 1, '0,       0,  0));
        directed.push_back(plan(1, 255, REQ_SEED,   32, 1, MID_ONLY, 1,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 31, 1, ALL_ON,   64, 2));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 0,  1, ALL_ON,   64, 2));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 63, 1, ALL_ON,   64, 3));
        directed.push_back(plan(1, 204, REQ_SEED,   63, 1, MID_ONLY, 1,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 31, 1, MID_ONLY, 1,  2));
        directed.push_back(plan(1, 90,  REQ_SEED,   31, 1, MID_ONLY, 1,  1));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 30, 0, '0,       0,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 0,  0, '0,       0,  0));
        directed.push_back(plan(1, 110, REQ_EVOLVE, 32, 0, '0,       0,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 1,  0, '0,       0,  0));
        directed.push_back(plan(1, 150, REQ_EVOLVE, 42, 0, '0,       0,  0));
        directed.push_back(plan(0, 0,   REQ_SEED,   21, 1, MID_ONLY, 1,  0));
        directed.push_back(plan(0, 0,   REQ_EVOLVE, 31, 0, '0,       0,  0));

        // Random part, one phase per rule. Rule 255 and rule 204 run long
        // without reseeding so that totals climb to their ceiling and stay
        // there; the other phases reseed now and then, rule 0 often, since
        // it goes dark after a single step.
        phases.push_back(phase(0,   115, 4));
        phases.push_back(phase(255, 200, 0));
        phases.push_back(phase(30,  115, 20));
        phases.push_back(phase(204, 180, 0));
        phases.push_back(phase(90,  115, 20));
        phases.push_back(phase(110, 115, 20));
        phases.push_back(phase(184, 115, 20));
        phases.push_back(phase(150, 115, 20));
        phases.push_back(phase(-1,  115, 20));
        phases.push_back(phase(-1,  115, 20));
        phases.push_back(phase(-1,  115, 20));

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            p = directed[i];
            if (p.load_rule) begin
                drain_block();
                load_rule(p.rule);
            end
            w.req_type   = p.req;
            w.cell_index = p.idx;
            typed_gen.row_bits     = p.row;
            typed_gen.active_count = p.count;
            typed_gen.cell_total   = p.total;
            offer_word(w, p.typed, typed_gen);
        end

        typed_gen = '0;
        foreach (phases[i]) begin
            ph = phases[i];
            rule = (ph.rule < 0) ? $urandom_range(0, 255) : ph.rule;
            drain_block();
            load_rule(rule[RULE_W-1:0]);
            for (int n = 0; n < ph.words; n++) begin
                // Each phase opens with a fresh seed about half the time, or
                // always where it never reseeds, so the long runs start from
                // a known row; after that seeds are sprinkled at random.
                if (n == 0) begin
                    w.req_type = (ph.seed_one_in == 0 || $urandom_range(0, 1) == 1)
                                 ? REQ_SEED : REQ_EVOLVE;
                end else if (ph.seed_one_in != 0 && $urandom_range(1, ph.seed_one_in) == 1) begin
                    w.req_type = REQ_SEED;
                end else begin
                    w.req_type = REQ_EVOLVE;
                end
                w.cell_index = IDX_W'($urandom_range(0, CELLS - 1));
                offer_word(w, 1'b0, typed_gen);
            end
        end

        // Everything has been accepted; wait for the last results, then a
        // little longer so any extra word would still be caught.
        drain_block();

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
